>>> design/hslp_pkg.sv
`timescale 1ns / 1ps

package hslp_pkg;

	// Result codes carried on the master-side tuser.
	localparam int RES_W = 2;
	localparam logic [RES_W-1:0] RES_MORE = 2'd0;
	localparam logic [RES_W-1:0] RES_DONE = 2'd1;
	localparam logic [RES_W-1:0] RES_BAD  = 2'd2;

	// Command codes carried on the slave-side tuser.
	localparam logic CMD_DATA    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Field widths of a result.
	localparam int CODE_W = 10;
	localparam int OFFS_W = 12;

	// Characters the status line is checked against.
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

endpackage

>>> design/http_status_line_parser_core.sv
`timescale 1ns / 1ps

// Channel   | Direction | tdata (low bit up)                              | tuser
// ----------+-----------+-------------------------------------------------+-------------
// s_*       | in        | data_byte[7:0]                                  | cmd[0]
// m_*       | out       | status_code[9:0], text_start[21:10],            | result[1:0]
//           |           | text_end[33:22], zero fill[39:34]               |
//
// Each byte request is shown as a result after it is accepted: it waits in
// the input register, then the parse step writes the result register. A new
// byte can be accepted every cycle while m_tready does not stall the result;
// the throughput is then one byte per cycle, set by the parser state update.
// Reset (arst_n low) empties both registers and puts the parser at the start
// of a line. A stall on m_tready holds the result, and the input register is
// then held too, so s_tready drops only while both registers are full.

module http_status_line_parser_core #(
	parameter int MAX_LINE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic [0:0]  s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // status_code[9:0], text_start[21:10], text_end[33:22]
	output logic [1:0]  m_tuser    // result[1:0]
);

	// Line offsets are kept just wide enough to hold MAX_LINE - 1, and are
	// reported through the fixed 12-bit result fields, keeping the low bits.
	localparam int OFS_W = $clog2(MAX_LINE);
	localparam int EXT_W = OFS_W + hslp_pkg::OFFS_W;
	localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_LINE - 1);

	// Parser phases.
	localparam logic [3:0] PH_START      = 4'd0;
	localparam logic [3:0] PH_H          = 4'd1;
	localparam logic [3:0] PH_HT         = 4'd2;
	localparam logic [3:0] PH_HTT        = 4'd3;
	localparam logic [3:0] PH_HTTP       = 4'd4;
	localparam logic [3:0] PH_MAJ_FIRST  = 4'd5;
	localparam logic [3:0] PH_MAJ        = 4'd6;
	localparam logic [3:0] PH_MIN_FIRST  = 4'd7;
	localparam logic [3:0] PH_MIN        = 4'd8;
	localparam logic [3:0] PH_CODE       = 4'd9;
	localparam logic [3:0] PH_AFTER_CODE = 4'd10;
	localparam logic [3:0] PH_TEXT       = 4'd11;
	localparam logic [3:0] PH_CR_SEEN    = 4'd12;

	// Input register.
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic                                 valid_s2;
	logic [hslp_pkg::RES_W-1:0]           result_s2;
	logic [hslp_pkg::CODE_W-1:0]          code_s2;
	logic [hslp_pkg::OFFS_W-1:0]          start_s2;
	logic [hslp_pkg::OFFS_W-1:0]          end_s2;

	// Parser state.
	logic [3:0]                  phase_q;
	logic [hslp_pkg::CODE_W-1:0] code_q;
	logic [1:0]                  count_q;
	logic [OFS_W-1:0]            offset_q;
	logic [OFS_W-1:0]            start_q;

	// Parse step.
	logic                        adv_s1;
	logic [3:0]                  phase_nxt;
	logic [hslp_pkg::CODE_W-1:0] code_nxt;
	logic [1:0]                  count_nxt;
	logic [OFS_W-1:0]            start_nxt;
	logic [OFS_W-1:0]            end_nxt;
	logic [hslp_pkg::RES_W-1:0]  res_nxt;
	logic                        is_dig;
	logic [3:0]                  dig_val;
	logic [7:0]                  dig_diff;
	logic [13:0]                 code_mac;
	logic [EXT_W-1:0]            start_ext;
	logic [EXT_W-1:0]            end_ext;

	// The input register moves on whenever the result register is empty or
	// its content is taken in this cycle.
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	assign is_dig   = (byte_s1 >= hslp_pkg::CH_ZERO) && (byte_s1 <= hslp_pkg::CH_NINE);
	assign dig_diff = byte_s1 - hslp_pkg::CH_ZERO;
	assign dig_val  = dig_diff[3:0];
	// Status code gathers in decimal and wraps within its 10 bits.
	assign code_mac = (14'(code_q) * 14'd10) + 14'(dig_val);

	always_comb begin
		phase_nxt = phase_q;
		code_nxt  = code_q;
		count_nxt = count_q;
		start_nxt = start_q;
		end_nxt   = '0;
		res_nxt   = hslp_pkg::RES_MORE;
		case (phase_q)
			PH_START: begin
				if (byte_s1 == hslp_pkg::CH_H) phase_nxt = PH_H;
				else res_nxt = hslp_pkg::RES_BAD;
			end
			PH_H: begin
				if (byte_s1 == hslp_pkg::CH_T) phase_nxt = PH_HT;
				else res_nxt = hslp_pkg::RES_BAD;
			end
			PH_HT: begin
				if (byte_s1 == hslp_pkg::CH_T) phase_nxt = PH_HTT;
				else res_nxt = hslp_pkg::RES_BAD;
			end
			PH_HTT: begin
				if (byte_s1 == hslp_pkg::CH_P) phase_nxt = PH_HTTP;
				else res_nxt = hslp_pkg::RES_BAD;
			end
			PH_HTTP: begin
				if (byte_s1 == hslp_pkg::CH_SLASH) phase_nxt = PH_MAJ_FIRST;
				else res_nxt = hslp_pkg::RES_BAD;
			end
			PH_MAJ_FIRST: begin
				// A major version may not open with a zero.
				if (byte_s1 >= hslp_pkg::CH_ONE && byte_s1 <= hslp_pkg::CH_NINE) begin
					phase_nxt = PH_MAJ;
				end else begin
					res_nxt = hslp_pkg::RES_BAD;
				end
			end
			PH_MAJ: begin
				if (byte_s1 == hslp_pkg::CH_DOT) phase_nxt = PH_MIN_FIRST;
				else if (!is_dig) res_nxt = hslp_pkg::RES_BAD;
			end
			PH_MIN_FIRST: begin
				if (is_dig) phase_nxt = PH_MIN;
				else res_nxt = hslp_pkg::RES_BAD;
			end
			PH_MIN: begin
				if (byte_s1 == hslp_pkg::CH_SPACE) phase_nxt = PH_CODE;
				else if (!is_dig) res_nxt = hslp_pkg::RES_BAD;
			end
			PH_CODE: begin
				// Spaces before or between the status digits are skipped.
				if (byte_s1 != hslp_pkg::CH_SPACE) begin
					if (!is_dig) begin
						res_nxt = hslp_pkg::RES_BAD;
					end else begin
						if (count_q == 2'd0) start_nxt = offset_q;
						code_nxt = code_mac[hslp_pkg::CODE_W-1:0];
						if (count_q >= 2'd2) begin
							count_nxt = 2'd0;
							phase_nxt = PH_AFTER_CODE;
						end else begin
							count_nxt = count_q + 2'd1;
						end
					end
				end
			end
			PH_AFTER_CODE: begin
				if (byte_s1 == hslp_pkg::CH_SPACE || byte_s1 == hslp_pkg::CH_DOT) begin
					phase_nxt = PH_TEXT;
				end else if (byte_s1 == hslp_pkg::CH_CR) begin
					phase_nxt = PH_CR_SEEN;
				end else if (byte_s1 == hslp_pkg::CH_LF) begin
					res_nxt = hslp_pkg::RES_DONE;
					end_nxt = offset_q;
				end else begin
					res_nxt = hslp_pkg::RES_BAD;
				end
			end
			PH_TEXT: begin
				if (byte_s1 == hslp_pkg::CH_CR) begin
					phase_nxt = PH_CR_SEEN;
				end else if (byte_s1 == hslp_pkg::CH_LF) begin
					res_nxt = hslp_pkg::RES_DONE;
					end_nxt = offset_q;
				end
			end
			PH_CR_SEEN: begin
				// The line ends at the CR, one byte before the LF.
				if (byte_s1 == hslp_pkg::CH_LF) begin
					res_nxt = hslp_pkg::RES_DONE;
					end_nxt = (offset_q != '0) ? offset_q - OFS_W'(1) : '0;
				end else begin
					res_nxt = hslp_pkg::RES_BAD;
				end
			end
			default: begin
				res_nxt = hslp_pkg::RES_BAD;
			end
		endcase
	end

	assign start_ext = EXT_W'(start_q);
	assign end_ext   = EXT_W'(end_nxt);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser[0];
			byte_s1 <= s_tdata;
		end
	end

	// Parser state. A restart, a complete line and an error all bring the
	// parser back to the start of a line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			code_q   <= '0;
			count_q  <= '0;
			offset_q <= '0;
			start_q  <= '0;
		end else if (adv_s1) begin
			if (cmd_s1 == hslp_pkg::CMD_RESTART || res_nxt != hslp_pkg::RES_MORE) begin
				phase_q  <= PH_START;
				code_q   <= '0;
				count_q  <= '0;
				offset_q <= '0;
				start_q  <= '0;
			end else begin
				phase_q <= phase_nxt;
				code_q  <= code_nxt;
				count_q <= count_nxt;
				start_q <= start_nxt;
				// The offset stops at the last position of a maximum-length line.
				if (offset_q < OFS_MAX) offset_q <= offset_q + OFS_W'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			if (cmd_s1 == hslp_pkg::CMD_RESTART) begin
				result_s2 <= hslp_pkg::RES_MORE;
				code_s2   <= '0;
				start_s2  <= '0;
				end_s2    <= '0;
			end else begin
				result_s2 <= res_nxt;
				if (res_nxt == hslp_pkg::RES_DONE) begin
					code_s2  <= code_q;
					start_s2 <= start_ext[hslp_pkg::OFFS_W-1:0];
					end_s2   <= end_ext[hslp_pkg::OFFS_W-1:0];
				end else begin
					code_s2  <= '0;
					start_s2 <= '0;
					end_s2   <= '0;
				end
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2;
	assign m_tdata  = {6'd0, end_s2, start_s2, code_s2};

	// The digit count never passes two; the third digit clears it.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("status digit count out of range");

	// At the start of a line nothing has been consumed yet.
	a_start_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_START) |-> (offset_q == '0 && count_q == 2'd0 && code_q == '0))
		else $error("start phase with leftover line state");

	// A processed restart leaves the parser at the start of a line.
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && cmd_s1 == hslp_pkg::CMD_RESTART) |=> (phase_q == PH_START))
		else $error("restart did not clear the parser");

	// Only a complete line carries code and offsets.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != hslp_pkg::RES_DONE) |-> (m_tdata == '0))
		else $error("result fields set without a complete line");

	// The line offset saturates at the last position of a maximum-length line.
	a_offset_sat: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= OFS_MAX)
		else $error("line offset past its limit");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// Offsets stop growing one short of the longest line the core accepts.
	localparam int LINE_MAX = 4096;
	localparam int DIRECTED_COUNT = 23;
	localparam int RANDOM_COUNT = 650;

	// Parser phases, one per character class still expected on the line.
	typedef enum logic [3:0] {
		LN_START, LN_H, LN_HT, LN_HTT, LN_HTTP, LN_MAJ0, LN_MAJ, LN_MIN0, LN_MIN,
		LN_CODE, LN_POST, LN_TEXT, LN_CR
	} line_phase_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} byte_req_t;

	typedef struct packed {
		logic [hslp_pkg::RES_W-1:0]  res;
		logic [hslp_pkg::CODE_W-1:0] code;
		logic [hslp_pkg::OFFS_W-1:0] first;
		logic [hslp_pkg::OFFS_W-1:0] last;
	} line_verdict_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic [0:0] s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0] m_tuser;

	http_status_line_parser_core #(
		.MAX_LINE(LINE_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Byte requests waiting to be offered, and verdicts waiting to come back.
	byte_req_t byte_reqs[$];
	line_verdict_t verdicts_due[$];
	int err_count = 0;

	// Our own copy of the parser state.
	line_phase_t ln_phase = LN_START;
	logic [hslp_pkg::CODE_W-1:0] ln_code = '0;
	int ln_digits = 0;
	int ln_offs = 0;
	int ln_first = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic byte_req_t mk_req(input logic cmd, input logic [7:0] data);
		byte_req_t r;
		r.cmd = cmd;
		r.data = data;
		return r;
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'(hslp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic clear_line();
		ln_phase = LN_START;
		ln_code = '0;
		ln_digits = 0;
		ln_offs = 0;
		ln_first = 0;
	endtask

	// Advances the parser copy by one accepted request and queues the verdict
	// the core must give for it.
	task automatic parse_byte(input logic cmd, input logic [7:0] c);
		line_verdict_t v;
		line_phase_t nx;
		int end_off;
		bit is_dig;
		v = '0;
		v.res = hslp_pkg::RES_MORE;
		nx = ln_phase;
		end_off = 0;
		is_dig = (c >= hslp_pkg::CH_ZERO) && (c <= hslp_pkg::CH_NINE);
		if (cmd == hslp_pkg::CMD_RESTART) begin
			clear_line();
		end else begin
			case (ln_phase)
				LN_START: if (c == hslp_pkg::CH_H) nx = LN_H; else v.res = hslp_pkg::RES_BAD;
				LN_H: if (c == hslp_pkg::CH_T) nx = LN_HT; else v.res = hslp_pkg::RES_BAD;
				LN_HT: if (c == hslp_pkg::CH_T) nx = LN_HTT; else v.res = hslp_pkg::RES_BAD;
				LN_HTT: if (c == hslp_pkg::CH_P) nx = LN_HTTP; else v.res = hslp_pkg::RES_BAD;
				LN_HTTP: begin
					if (c == hslp_pkg::CH_SLASH) nx = LN_MAJ0;
					else v.res = hslp_pkg::RES_BAD;
				end
				LN_MAJ0: begin
					// The major version may not start with a zero.
					if (c >= hslp_pkg::CH_ONE && c <= hslp_pkg::CH_NINE) nx = LN_MAJ;
					else v.res = hslp_pkg::RES_BAD;
				end
				LN_MAJ: begin
					if (c == hslp_pkg::CH_DOT) nx = LN_MIN0;
					else if (!is_dig) v.res = hslp_pkg::RES_BAD;
				end
				LN_MIN0: if (is_dig) nx = LN_MIN; else v.res = hslp_pkg::RES_BAD;
				LN_MIN: begin
					if (c == hslp_pkg::CH_SPACE) nx = LN_CODE;
					else if (!is_dig) v.res = hslp_pkg::RES_BAD;
				end
				LN_CODE: begin
					// Spaces before or between the status digits are skipped; the text
					// start stays at the first digit.
					if (c == hslp_pkg::CH_SPACE) begin
					end else if (!is_dig) begin
						v.res = hslp_pkg::RES_BAD;
					end else begin
						if (ln_digits == 0) ln_first = ln_offs;
						ln_code = 10'(int'(ln_code) * 10 + int'(c - hslp_pkg::CH_ZERO));
						if (ln_digits >= 2) begin
							ln_digits = 0;
							nx = LN_POST;
						end else begin
							ln_digits++;
						end
					end
				end
				LN_POST: begin
					if (c == hslp_pkg::CH_SPACE || c == hslp_pkg::CH_DOT) nx = LN_TEXT;
					else if (c == hslp_pkg::CH_CR) nx = LN_CR;
					else if (c == hslp_pkg::CH_LF) begin
						v.res = hslp_pkg::RES_DONE;
						end_off = ln_offs;
					end else v.res = hslp_pkg::RES_BAD;
				end
				LN_TEXT: begin
					if (c == hslp_pkg::CH_CR) nx = LN_CR;
					else if (c == hslp_pkg::CH_LF) begin
						v.res = hslp_pkg::RES_DONE;
						end_off = ln_offs;
					end
				end
				LN_CR: begin
					// The line end is reported at the CR, one before this LF.
					if (c == hslp_pkg::CH_LF) begin
						v.res = hslp_pkg::RES_DONE;
						end_off = (ln_offs > 0) ? ln_offs - 1 : 0;
					end else v.res = hslp_pkg::RES_BAD;
				end
				default: v.res = hslp_pkg::RES_BAD;
			endcase
			if (v.res == hslp_pkg::RES_DONE) begin
				v.code = ln_code;
				v.first = 12'(ln_first);
				v.last = 12'(end_off);
			end
			if (v.res != hslp_pkg::RES_MORE) begin
				clear_line();
			end else begin
				ln_phase = nx;
				if (ln_offs < LINE_MAX - 1) ln_offs++;
			end
		end
		verdicts_due.push_back(v);
	endtask

	task automatic check_verdict();
		line_verdict_t want;
		if (verdicts_due.size() == 0) begin
			flag_error($sformatf("verdict %0d with no request outstanding", m_tuser));
		end else begin
			want = verdicts_due.pop_front();
			if (m_tuser !== want.res)
				flag_error($sformatf("result %0d, expected %0d", m_tuser, want.res));
			if (m_tdata[9:0] !== want.code)
				flag_error($sformatf("status_code %0d, expected %0d",
					m_tdata[9:0], want.code));
			if (m_tdata[21:10] !== want.first)
				flag_error($sformatf("text_start %0d, expected %0d",
					m_tdata[21:10], want.first));
			if (m_tdata[33:22] !== want.last)
				flag_error($sformatf("text_end %0d, expected %0d",
					m_tdata[33:22], want.last));
		end
	endtask

	// Handshake monitor. Both channels are sampled at the rising edge; the
	// taken flags tell the falling-edge drivers what moved at that edge.
	logic req_taken = 1'b0;
	logic res_taken = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taken <= 1'b0;
			res_taken <= 1'b0;
			clear_line();
		end else begin
			req_taken <= s_tvalid && s_tready;
			res_taken <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) parse_byte(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready) check_verdict();
		end
	end

	// Request driver. Each request draws its own random idle gap, which may
	// be empty, before the next one; now and then the driver flips into a calm
	// stretch with no gaps at all, so back-to-back bursts are exercised too.
	int src_gap = 0;
	bit src_calm = 1'b0;
	byte_req_t cur_req;

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !req_taken) begin
			// The request on the bus has not been taken yet; hold it.
		end else if (src_gap > 0) begin
			s_tvalid <= 1'b0;
			src_gap <= src_gap - 1;
		end else if (byte_reqs.size() > 0) begin
			cur_req = byte_reqs.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= cur_req.data;
			s_tuser <= cur_req.cmd;
			src_gap <= src_calm ? 0 : $urandom_range(0, 5);
			if ($urandom_range(0, 31) == 0) src_calm <= !src_calm;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Verdict receiver. After every verdict it takes, it may stall for a
	// random stretch, again with calm stretches where it never stalls.
	int snk_stall = 0;
	bit snk_calm = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (res_taken) snk_stall = snk_calm ? 0 : $urandom_range(0, 5);
			if (snk_stall > 0) begin
				m_tready <= 1'b0;
				snk_stall = snk_stall - 1;
			end else begin
				m_tready <= 1'b1;
			end
			if ($urandom_range(0, 31) == 0) snk_calm = !snk_calm;
		end
	end

	task automatic queue_str(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_reqs.push_back(mk_req(hslp_pkg::CMD_DATA, s[i]));
	endtask

	// Builds one status line: version, status digits with optional spaces,
	// then an end of line, with or without text before it. When allowed, a
	// quarter of the lines are damaged: a byte overwritten, the line cut
	// short (with or without a restart), or the CR followed by something
	// other than LF.
	task automatic queue_line(input int minor_len, input int text_len, input bit may_break);
		byte_req_t line[$];
		logic [7:0] t;
		int cut;
		line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_H));
		line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_T));
		line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_T));
		line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_P));
		line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_SLASH));
		line.push_back(mk_req(hslp_pkg::CMD_DATA,
			8'(hslp_pkg::CH_ONE + 8'($urandom_range(0, 8)))));
		repeat ($urandom_range(0, 3))
			line.push_back(mk_req(hslp_pkg::CMD_DATA, rand_digit()));
		line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_DOT));
		repeat (minor_len) line.push_back(mk_req(hslp_pkg::CMD_DATA, rand_digit()));
		line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_SPACE));
		repeat (3) begin
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2))
					line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_SPACE));
			line.push_back(mk_req(hslp_pkg::CMD_DATA, rand_digit()));
		end
		if (text_len > 0) begin
			line.push_back(mk_req(hslp_pkg::CMD_DATA,
				$urandom_range(0, 1) ? hslp_pkg::CH_SPACE : hslp_pkg::CH_DOT));
			repeat (text_len) begin
				do t = 8'($urandom_range(0, 255));
				while (t == hslp_pkg::CH_CR || t == hslp_pkg::CH_LF);
				line.push_back(mk_req(hslp_pkg::CMD_DATA, t));
			end
		end
		if ($urandom_range(0, 2) != 0)
			line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_CR));
		line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_LF));
		if (may_break && $urandom_range(0, 3) == 0) begin
			cut = $urandom_range(0, line.size() - 1);
			case ($urandom_range(0, 3))
				0: line[cut].data = 8'($urandom_range(0, 255));
				1: begin
					while (line.size() > cut) void'(line.pop_back());
					line.push_back(mk_req(hslp_pkg::CMD_RESTART, 8'($urandom_range(0, 255))));
				end
				2: while (line.size() > cut) void'(line.pop_back());
				default: begin
					void'(line.pop_back());
					if (line[line.size() - 1].data == hslp_pkg::CH_CR) void'(line.pop_back());
					line.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_CR));
					do t = 8'($urandom_range(0, 255)); while (t == hslp_pkg::CH_LF);
					line.push_back(mk_req(hslp_pkg::CMD_DATA, t));
				end
			endcase
		end
		foreach (line[i]) byte_reqs.push_back(line[i]);
	endtask

	// Stimulus and end of run.
	initial begin
		// Directed part: the highest version digit and status code with a bare
		// LF, the lowest and highest byte values at the start of a line, a
		// restart in the middle of a line, and a major version starting at 0.
		queue_str("HTTP/9.0 999");
		byte_reqs.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_LF));
		byte_reqs.push_back(mk_req(hslp_pkg::CMD_DATA, 8'h00));
		byte_reqs.push_back(mk_req(hslp_pkg::CMD_DATA, 8'hFF));
		byte_reqs.push_back(mk_req(hslp_pkg::CMD_DATA, hslp_pkg::CH_H));
		byte_reqs.push_back(mk_req(hslp_pkg::CMD_RESTART, 8'hFF));
		queue_str("HTTP/0");

		// Random part: mostly well-formed lines with random content, the rest
		// stray bytes and restarts.
		while (byte_reqs.size() < DIRECTED_COUNT + RANDOM_COUNT) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: queue_line($urandom_range(1, 3), $urandom_range(0, 12), 1'b1);
				7, 8: repeat ($urandom_range(1, 4))
					byte_reqs.push_back(mk_req(hslp_pkg::CMD_DATA, 8'($urandom_range(0, 255))));
				default: byte_reqs.push_back(mk_req(hslp_pkg::CMD_RESTART,
					8'($urandom_range(0, 255))));
			endcase
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_reqs.size() > 0 || s_tvalid) @(posedge clk);
		while (verdicts_due.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (err_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run of several hundred
	// requests with the longest gaps and stalls.
	initial begin
		#2000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> http_status_line_parser_core.f
design/hslp_pkg.sv
design/http_status_line_parser_core.sv
verif/testbench.sv
